// ===== rtl/frt_pkg.sv =====
// shared types and constants of the fragment reassembly tracker
`default_nettype none

package frt_pkg;

    localparam int LEN_BITS  = 32;
    localparam int ID_BITS   = 63;
    localparam int IDX_BITS  = 32;
    localparam int FLEN_BITS = 16;
    localparam int OUT_BITS  = 32;

    localparam logic CMD_FRAGMENT = 1'b0;
    localparam logic CMD_ABORT    = 1'b1;

    typedef enum logic [2:0] {
        ST_PARTIAL  = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_PROTO    = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        logic                 cmd;
        logic [ID_BITS-1:0]   action_id;
        logic [IDX_BITS-1:0]  frag_index;
        logic [LEN_BITS-1:0]  action_size;
        logic [FLEN_BITS-1:0] frag_length;
        logic                 is_local;
    } frag_item_t;

    typedef struct packed {
        status_t             status;
        logic [OUT_BITS-1:0] write_offset;
        logic [OUT_BITS-1:0] action_length;
        logic                alloc_request;
    } result_item_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] bytes_received;
        logic [IDX_BITS-1:0] frag_counter;
        logic [ID_BITS-1:0]  current_action;
        logic [LEN_BITS-1:0] expected_size;
        logic                abort_mark;
    } trk_state_t;

endpackage

`default_nettype wire

// ===== rtl/frt_decide.sv =====
// per-fragment decision logic: next tracker state and result
`default_nettype none

module frt_decide
    import frt_pkg::*;
(
    input  wire frag_item_t item,
    input  wire trk_state_t cur,
    output trk_state_t   nxt,
    output result_item_t res
);

    logic                busy;
    logic                id_match;
    logic [IDX_BITS-1:0] cnt_inc;
    logic                seq_ok;
    logic                restart_ok;
    logic                take;
    logic                alloc;
    trk_state_t          mid;
    logic [LEN_BITS:0]   sum;

    assign busy       = (cur.bytes_received != '0);
    assign id_match   = (cur.current_action == item.action_id);
    assign cnt_inc    = cur.frag_counter + IDX_BITS'(1);
    assign seq_ok     = id_match && (item.frag_index == cnt_inc);
    assign restart_ok = item.is_local && cur.abort_mark && id_match
                        && (item.frag_index == '0);

    // decide whether the fragment is taken and the state before byte accounting
    always_comb
    begin
        mid   = cur;
        take  = 1'b0;
        alloc = 1'b0;
        if (item.cmd == CMD_ABORT)
        begin
            mid.abort_mark = 1'b1;
        end
        else if (busy)
        begin
            if (seq_ok)
            begin
                take             = 1'b1;
                mid.frag_counter = cnt_inc;
            end
            else if (restart_ok)
            begin
                take               = 1'b1;
                mid.frag_counter   = '0;
                mid.bytes_received = '0;
                mid.abort_mark     = 1'b0;
                if (cur.expected_size != item.action_size)
                begin
                    mid.expected_size = item.action_size;
                    alloc             = 1'b1;
                end
            end
        end
        else if (item.frag_index == '0)
        begin
            take               = 1'b1;
            mid.expected_size  = item.action_size;
            mid.current_action = item.action_id;
            mid.abort_mark     = 1'b0;
            mid.frag_counter   = '0;
            alloc              = 1'b1;
        end
    end

    assign sum = {1'b0, mid.bytes_received}
               + {{(LEN_BITS + 1 - FLEN_BITS){1'b0}}, item.frag_length};

    // byte accounting and result
    always_comb
    begin
        nxt = cur;
        res = '{status: ST_PARTIAL, write_offset: '0, action_length: '0,
                alloc_request: 1'b0};
        if (item.cmd == CMD_ABORT)
        begin
            nxt        = mid;
            res.status = ST_IGNORED;
        end
        else if (!take)
        begin
            if (!busy && !item.is_local && cur.abort_mark)
                res.status = ST_IGNORED;
            else
                res.status = ST_PROTO;
        end
        else if (sum > {1'b0, mid.expected_size})
        begin
            nxt              = '0;
            res.status       = ST_OVERFLOW;
            res.write_offset = OUT_BITS'(mid.bytes_received);
        end
        else if (sum[LEN_BITS-1:0] == mid.expected_size)
        begin
            nxt               = '0;
            res.status        = ST_COMPLETE;
            res.write_offset  = OUT_BITS'(mid.bytes_received);
            res.action_length = OUT_BITS'(sum[LEN_BITS-1:0]);
            res.alloc_request = alloc;
        end
        else
        begin
            nxt                = mid;
            nxt.bytes_received = sum[LEN_BITS-1:0];
            res.status         = ST_PARTIAL;
            res.write_offset   = OUT_BITS'(mid.bytes_received);
            res.alloc_request  = alloc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fragment_reassembly_tracker_core.sv =====
// the result is registered from the held fragment once the result register can take it
// throughput: one fragment per cycle unless stalled, set by the single decision stage
// the tracker state is read and rewritten in that one stage, so consecutive fragments chain
// reset: rst_n low clears the tracker state and both valid flags at once, no clearing pass
// top level of the fragment reassembly tracker
`default_nettype none

module fragment_reassembly_tracker_core
    import frt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   frag_valid,
    output logic        frag_stall,
    input  wire frag_item_t frag,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_item_t result
);

    // input register: holds one accepted fragment transaction
    frag_item_t   item_reg;
    logic         item_valid_reg;

    // tracker state and result register
    trk_state_t   state_reg;
    trk_state_t   state_next;
    result_item_t result_reg;
    result_item_t result_next;
    logic         result_valid_reg;

    logic         frag_take;
    logic         fire;

    // the held item moves on whenever the result register is empty or being drained
    assign fire       = item_valid_reg && (!result_valid_reg || !result_stall);
    // stall only while the input register is full and cannot move on
    assign frag_stall = item_valid_reg && !fire;
    assign frag_take  = frag_valid && !frag_stall;

    // decision logic between the input register and the result register
    frt_decide u_decide
    (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // fragment payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (frag_take)
            item_reg <= frag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (frag_take)
            item_valid_reg <= 1'b1;
        else if (fire)
            item_valid_reg <= 1'b0;
    end

    // tracker state advances exactly once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (fire)
            state_reg <= state_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (fire)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/frt_checker.sv =====
// port-level checks of the fragment reassembly tracker and their binding
`default_nettype none

module frt_checker
    import frt_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   result_valid,
    input wire logic   result_stall,
    input wire result_item_t result
);

    // a stalled result transaction stays offered and unchanged
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // ignored and protocol-error results carry no offset, length or allocation
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_IGNORED || result.status == ST_PROTO)
        |-> result.write_offset == '0 && result.action_length == '0
            && !result.alloc_request)
        else $error("rejected fragment carries payload fields");

    // only a completed action reports a length
    a_length_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_COMPLETE |-> result.action_length == '0)
        else $error("action length outside completion");

    // a completed action is at least as long as the final write offset
    a_complete_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_COMPLETE
        |-> result.action_length >= result.write_offset)
        else $error("action length below write offset");

    // overflow never asks for a buffer
    a_overflow_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_OVERFLOW |-> !result.alloc_request)
        else $error("allocation on overflow");

endmodule

bind fragment_reassembly_tracker_core frt_checker u_frt_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
